### rtl/sstd_pkg.sv
// Shared constants, font table and status types of the scrolling segment text display.
// No dependencies; every other file except sstd_ram imports this package.
`timescale 1ns / 1ps

package sstd_pkg;

   localparam int DISPLAY_CHARS = 7;
   localparam int STORE_DEPTH   = 128;

   localparam int ADDR_W   = $clog2(STORE_DEPTH);
   localparam int CHAR_W   = 7;
   localparam int CNT_W    = 8;
   localparam int PAD_W    = 2;
   localparam int SCROLL_W = 9;
   localparam int DELAY_W  = 3;
   localparam int BASE_W   = 8;
   localparam int IDX_W    = 9;
   localparam int POS_W    = 3;
   localparam int SEG_W    = 16;
   localparam int K_W      = ($clog2(DISPLAY_CHARS) > POS_W) ? $clog2(DISPLAY_CHARS) : POS_W;

   localparam logic [CNT_W-1:0]   CNT_MAX    = {CNT_W{1'b1}};
   localparam logic [DELAY_W-1:0] DELAY_EDGE = 3'd4;
   localparam logic [DELAY_W-1:0] DELAY_STEP = 3'd2;
   localparam logic [PAD_W-1:0]   PAD_MAX    = 2'd2;

   localparam logic [CHAR_W-1:0] CHR_SPACE = 7'h20;
   localparam logic [CHAR_W-1:0] CHR_DOT   = 7'h2E;
   localparam logic [CHAR_W-1:0] CHR_COLON = 7'h3A;
   localparam logic [CHAR_W-1:0] CHR_SEMI  = 7'h3B;

   typedef enum logic {
      OP_LOAD = 1'b0,
      OP_TICK = 1'b1
   } op_type;

   typedef struct packed {
      logic [CNT_W-1:0]  char_count;
      logic [PAD_W-1:0]  pad_count;
      logic [BASE_W-1:0] base;
   } text_view_type;

   localparam logic [SEG_W-1:0] SG_A   = 16'h0080;
   localparam logic [SEG_W-1:0] SG_B   = 16'h0040;
   localparam logic [SEG_W-1:0] SG_C   = 16'h0020;
   localparam logic [SEG_W-1:0] SG_D   = 16'h0010;
   localparam logic [SEG_W-1:0] SG_E   = 16'h2000;
   localparam logic [SEG_W-1:0] SG_F   = 16'h4000;
   localparam logic [SEG_W-1:0] SG_G   = 16'h0400;
   localparam logic [SEG_W-1:0] SG_H   = 16'h0800;
   localparam logic [SEG_W-1:0] SG_J   = 16'h0008;
   localparam logic [SEG_W-1:0] SG_K   = 16'h0004;
   localparam logic [SEG_W-1:0] SG_M   = 16'h0002;
   localparam logic [SEG_W-1:0] SG_N   = 16'h0001;
   localparam logic [SEG_W-1:0] SG_P   = 16'h0100;
   localparam logic [SEG_W-1:0] SG_Q   = 16'h0200;
   localparam logic [SEG_W-1:0] SG_DOT = 16'h1000;
   localparam logic [SEG_W-1:0] SG_COL = 16'h8000;
   localparam logic [SEG_W-1:0] SG_OFF = 16'h0000;

   localparam logic [SEG_W-1:0] FONT [128] = '{
      // control codes
      SG_OFF, SG_OFF, SG_OFF, SG_OFF, SG_OFF, SG_OFF, SG_OFF, SG_OFF,
      SG_OFF, SG_OFF, SG_OFF, SG_OFF, SG_OFF, SG_OFF, SG_OFF, SG_OFF,
      SG_OFF, SG_OFF, SG_OFF, SG_OFF, SG_OFF, SG_OFF, SG_OFF, SG_OFF,
      SG_OFF, SG_OFF, SG_OFF, SG_OFF, SG_OFF, SG_OFF, SG_OFF, SG_OFF,
      // space to slash
      SG_OFF, SG_OFF, SG_F|SG_J, SG_OFF, SG_OFF,
      SG_F|SG_G|SG_H|SG_K|SG_Q|SG_M|SG_N|SG_C, SG_OFF, SG_J,
      SG_OFF, SG_OFF, SG_G|SG_H|SG_J|SG_K|SG_M|SG_N|SG_P|SG_Q, SG_G|SG_J|SG_M|SG_P,
      SG_DOT, SG_G|SG_M, SG_DOT, SG_K|SG_Q,
      // digits
      SG_A|SG_B|SG_C|SG_D|SG_E|SG_F, SG_B|SG_C,
      SG_A|SG_B|SG_G|SG_M|SG_D|SG_E, SG_A|SG_B|SG_G|SG_M|SG_C|SG_D,
      SG_B|SG_C|SG_G|SG_M|SG_F, SG_A|SG_C|SG_G|SG_M|SG_D|SG_F,
      SG_A|SG_C|SG_G|SG_M|SG_D|SG_E|SG_F, SG_A|SG_B|SG_C,
      SG_A|SG_B|SG_C|SG_G|SG_M|SG_D|SG_E|SG_F, SG_A|SG_B|SG_C|SG_G|SG_M|SG_D|SG_F,
      // colon to at sign
      SG_COL, SG_COL, SG_K|SG_N, SG_D|SG_G|SG_M, SG_H|SG_Q, SG_A|SG_B|SG_M|SG_P,
      SG_A|SG_B|SG_E|SG_F|SG_K|SG_M,
      // upper case
      SG_A|SG_B|SG_C|SG_G|SG_M|SG_E|SG_F, SG_A|SG_B|SG_C|SG_D|SG_J|SG_M|SG_P,
      SG_A|SG_D|SG_E|SG_F, SG_A|SG_B|SG_C|SG_D|SG_J|SG_P,
      SG_A|SG_D|SG_E|SG_F|SG_G, SG_A|SG_E|SG_F|SG_G,
      SG_A|SG_C|SG_D|SG_E|SG_F|SG_M, SG_B|SG_C|SG_E|SG_F|SG_G|SG_M,
      SG_A|SG_D|SG_J|SG_P, SG_B|SG_C|SG_D|SG_E,
      SG_E|SG_F|SG_G|SG_K|SG_N, SG_D|SG_E|SG_F,
      SG_B|SG_C|SG_E|SG_F|SG_H|SG_K, SG_B|SG_C|SG_E|SG_F|SG_H|SG_N,
      SG_A|SG_B|SG_C|SG_D|SG_E|SG_F, SG_A|SG_B|SG_E|SG_F|SG_G|SG_M,
      SG_A|SG_B|SG_C|SG_D|SG_E|SG_F|SG_N, SG_A|SG_B|SG_E|SG_F|SG_G|SG_M|SG_N,
      SG_A|SG_C|SG_D|SG_F|SG_G|SG_M, SG_A|SG_J|SG_P,
      SG_B|SG_C|SG_D|SG_E|SG_F, SG_E|SG_F|SG_K|SG_Q,
      SG_B|SG_C|SG_E|SG_F|SG_N|SG_Q, SG_H|SG_K|SG_N|SG_Q,
      SG_H|SG_K|SG_P, SG_A|SG_D|SG_K|SG_Q,
      // brackets to backquote
      SG_A|SG_D|SG_J|SG_P, SG_H|SG_N, SG_A|SG_D|SG_J|SG_P, SG_Q|SG_N, SG_D, SG_Q,
      // lower case
      SG_D|SG_E|SG_G|SG_N, SG_C|SG_D|SG_E|SG_F|SG_G|SG_M,
      SG_D|SG_E|SG_G|SG_M, SG_B|SG_C|SG_D|SG_E|SG_G|SG_M,
      SG_D|SG_E|SG_G|SG_Q, SG_A|SG_J|SG_M|SG_P,
      SG_C|SG_D|SG_M|SG_N, SG_C|SG_E|SG_F|SG_G|SG_M,
      SG_P, SG_P|SG_D, SG_J|SG_P|SG_N|SG_M, SG_D|SG_J|SG_P,
      SG_C|SG_E|SG_G|SG_M|SG_P, SG_C|SG_G|SG_M|SG_P,
      SG_C|SG_D|SG_E|SG_G|SG_M, SG_E|SG_F|SG_G|SG_H,
      SG_B|SG_C|SG_K|SG_M, SG_M|SG_P, SG_D|SG_M|SG_N, SG_G|SG_J|SG_M|SG_P,
      SG_C|SG_D|SG_E, SG_E|SG_Q, SG_C|SG_E|SG_N|SG_Q, SG_G|SG_M|SG_N|SG_Q,
      SG_C|SG_D|SG_N, SG_D|SG_G|SG_Q,
      // braces to delete
      SG_G|SG_J|SG_P, SG_J|SG_P, SG_J|SG_M|SG_P, SG_G|SG_M, SG_A|SG_B|SG_M|SG_P
   };

   function automatic logic [SEG_W-1:0] font_word(input logic [CHAR_W-1:0] ch);
      return FONT[ch];
   endfunction

   function automatic logic is_merge_mark(input logic [CHAR_W-1:0] ch);
      return (ch == CHR_DOT) || (ch == CHR_COLON) || (ch == CHR_SEMI);
   endfunction

endpackage

### rtl/sstd_if.sv
// Valid/ready channel interfaces for requests and display words.
// Depends on sstd_pkg for field widths.
`timescale 1ns / 1ps

interface sstd_req_if;
   import sstd_pkg::*;

   logic              valid;
   logic              ready;
   logic              op;
   logic [CHAR_W-1:0] char_code;
   logic              last;

   modport source (output valid, output op, output char_code, output last, input ready);
   modport sink   (input valid, input op, input char_code, input last, output ready);
endinterface

interface sstd_rsp_if;
   import sstd_pkg::*;

   logic             valid;
   logic             ready;
   logic [POS_W-1:0] position;
   logic [SEG_W-1:0] segments;
   logic             last_word;

   modport source (output valid, output position, output segments, output last_word,
                   input ready);
   modport sink   (input valid, input position, input segments, input last_word,
                   output ready);
endinterface

### rtl/scrolling_segment_text_display.sv
// Scrolling 14-segment text line. A refresh tick emits one word per display position;
// each position steps through fetch, first read, a second read when a mark merges, and
// emit, which holds until the sink is ready. The single read port of the text memory sets
// this: each cell is one addressed read with registered data. The next request is taken
// once the last word of a refresh has transferred.
// Synchronous active-high reset clears counts, padding, scroll state and sequencer;
// the text memory is not cleared.
`timescale 1ns / 1ps

module scrolling_segment_text_display (
   input  logic       clock,
   input  logic       reset,
   sstd_req_if.sink   req_chan,
   sstd_rsp_if.source rsp_chan
);
   import sstd_pkg::*;

   text_view_type     view;
   logic              idle;
   logic              accept, load_en, tick_en;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr, rd_addr;
   logic [CHAR_W-1:0] wr_data, rd_data;

   assign req_chan.ready = idle;
   assign accept         = req_chan.valid && idle;
   assign load_en        = accept && (req_chan.op == OP_LOAD);
   assign tick_en        = accept && (req_chan.op == OP_TICK);

   sstd_text_ctl u_text_ctl (
      .clock     (clock),
      .reset     (reset),
      .load_en   (load_en),
      .tick_en   (tick_en),
      .load_char (req_chan.char_code),
      .load_last (req_chan.last),
      .view      (view),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data)
   );

   sstd_ram #(
      .DEPTH (STORE_DEPTH),
      .WIDTH (CHAR_W)
   ) u_text_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   sstd_render u_render (
      .clock   (clock),
      .reset   (reset),
      .start   (tick_en),
      .view    (view),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .idle    (idle),
      .rsp     (rsp_chan)
   );

endmodule

### rtl/sstd_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module sstd_ram #(
   parameter int DEPTH = 128,
   parameter int WIDTH = 7
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/sstd_text_ctl.sv
// Text bookkeeping: store writes, length and padding, scroll position and delay.
// Depends on sstd_pkg.
`timescale 1ns / 1ps

module sstd_text_ctl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        load_en,
   input  logic                        tick_en,
   input  logic [sstd_pkg::CHAR_W-1:0] load_char,
   input  logic                        load_last,
   output sstd_pkg::text_view_type     view,
   output logic                        wr_en,
   output logic [sstd_pkg::ADDR_W-1:0] wr_addr,
   output logic [sstd_pkg::CHAR_W-1:0] wr_data
);
   import sstd_pkg::*;

   logic [CNT_W-1:0]           char_count_ff, char_count_in;
   logic [CNT_W-1:0]           vis_len_ff, vis_len_in;
   logic [PAD_W-1:0]           pad_ff, pad_in;
   logic signed [SCROLL_W-1:0] pos_ff, pos_in;
   logic [DELAY_W-1:0]         delay_ff, delay_in;
   logic                       closed_ff, closed_in;

   logic [CNT_W-1:0]           cc_base, vl_base, vl_inc, excess;
   logic [PAD_W-1:0]           pad_base, pad_new;
   logic [CNT_W:0]             vl_padded;
   logic signed [SCROLL_W-1:0] pos_step, pos_inc, pos_new;
   logic [DELAY_W-1:0]         delay_step;
   logic signed [SCROLL_W:0]   reach;
   logic                       wrap;
   logic [SCROLL_W-1:0]        pos_abs;

   // load path
   always_comb begin
      cc_base  = closed_ff ? '0 : char_count_ff;
      vl_base  = closed_ff ? '0 : vis_len_ff;
      pad_base = closed_ff ? '0 : pad_ff;
      wr_en    = load_en && ({1'b0, cc_base} < (CNT_W+1)'(STORE_DEPTH));
      wr_addr  = cc_base[ADDR_W-1:0];
      wr_data  = load_char;
      vl_inc   = vl_base;
      if ((load_char != CHR_DOT) && (load_char != CHR_COLON) && (vl_base != CNT_MAX)) begin
         vl_inc = vl_base + CNT_W'(1);
      end
      excess    = vl_inc - CNT_W'(DISPLAY_CHARS);
      pad_new   = (excess > CNT_W'(PAD_MAX)) ? PAD_MAX : excess[PAD_W-1:0];
      vl_padded = {1'b0, vl_inc} + (CNT_W+1)'({pad_new, 1'b0});
   end

   // scroll path
   always_comb begin
      pos_inc    = pos_ff + SCROLL_W'(1);
      pos_step   = pos_ff;
      delay_step = delay_ff;
      if (vis_len_ff > CNT_W'(DISPLAY_CHARS)) begin
         if (delay_ff == '0) begin
            pos_step   = pos_inc;
            delay_step = (pos_inc == '0) ? DELAY_EDGE : DELAY_STEP;
         end
         delay_step = delay_step - DELAY_W'(1);
      end
      reach   = $signed({pos_step[SCROLL_W-1], pos_step})
              + $signed((SCROLL_W+1)'(DISPLAY_CHARS + 1));
      wrap    = reach > $signed({2'b00, vis_len_ff});
      pos_new = wrap ? (SCROLL_W'(0) - pos_step) : pos_step;
      pos_abs = pos_new[SCROLL_W-1] ? (SCROLL_W'(0) - pos_new) : pos_new;
   end

   always_comb begin
      char_count_in = char_count_ff;
      vis_len_in    = vis_len_ff;
      pad_in        = pad_ff;
      pos_in        = pos_ff;
      delay_in      = delay_ff;
      closed_in     = closed_ff;
      if (load_en) begin
         char_count_in = (cc_base != CNT_MAX) ? cc_base + CNT_W'(1) : cc_base;
         vis_len_in    = vl_inc;
         pad_in        = pad_base;
         pos_in        = '0;
         closed_in     = load_last;
         if (load_last && (vl_inc > CNT_W'(DISPLAY_CHARS))) begin
            pad_in     = pad_new;
            vis_len_in = vl_padded[CNT_W] ? CNT_MAX : vl_padded[CNT_W-1:0];
         end
      end else if (tick_en) begin
         pos_in   = pos_new;
         delay_in = wrap ? DELAY_EDGE : delay_step;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         char_count_ff <= '0;
         vis_len_ff    <= '0;
         pad_ff        <= '0;
         pos_ff        <= '0;
         delay_ff      <= '0;
         closed_ff     <= 1'b0;
      end else begin
         char_count_ff <= char_count_in;
         vis_len_ff    <= vis_len_in;
         pad_ff        <= pad_in;
         pos_ff        <= pos_in;
         delay_ff      <= delay_in;
         closed_ff     <= closed_in;
      end
   end

   assign view.char_count = char_count_ff;
   assign view.pad_count  = pad_ff;
   assign view.base       = pos_abs[BASE_W-1:0];

endmodule

### rtl/sstd_render.sv
// Refresh sequencer: reads cells from the text memory, merges marks, emits segment words.
// Depends on sstd_pkg and sstd_rsp_if.
`timescale 1ns / 1ps

module sstd_render (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  sstd_pkg::text_view_type     view,
   output logic [sstd_pkg::ADDR_W-1:0] rd_addr,
   input  logic [sstd_pkg::CHAR_W-1:0] rd_data,
   output logic                        idle,
   sstd_rsp_if.source                  rsp
);
   import sstd_pkg::*;

   typedef enum logic [2:0] {
      R_IDLE,
      R_FETCH,
      R_FIRST,
      R_SECOND,
      R_EMIT
   } render_state_type;

   localparam logic [K_W-1:0] LAST_K = K_W'(DISPLAY_CHARS - 1);

   render_state_type  state_ff;
   logic [IDX_W-1:0]  idx_ff;
   logic [K_W-1:0]    k_ff;
   logic [SEG_W-1:0]  word_ff;
   logic              hit_ff;

   logic [IDX_W-1:0]  look_idx, off;
   logic              hit;
   logic [CHAR_W-1:0] ch;
   logic [SEG_W-1:0]  glyph;

   always_comb begin
      look_idx = (state_ff == R_FIRST) ? idx_ff + IDX_W'(1) : idx_ff;
      off      = look_idx - IDX_W'(view.pad_count);
      hit      = (look_idx >= IDX_W'(view.pad_count))
              && (off < IDX_W'(view.char_count))
              && (off < IDX_W'(STORE_DEPTH));
      rd_addr  = off[ADDR_W-1:0];
      ch       = hit_ff ? rd_data : CHR_SPACE;
      glyph    = font_word(ch);
   end

   always_ff @(posedge clock) begin
      hit_ff <= hit;
      if (reset) begin
         state_ff <= R_IDLE;
         k_ff     <= '0;
      end else begin
         unique case (state_ff)
            R_IDLE: begin
               if (start) begin
                  idx_ff   <= IDX_W'(view.base);
                  k_ff     <= '0;
                  state_ff <= R_FETCH;
               end
            end
            R_FETCH: begin
               state_ff <= R_FIRST;
            end
            R_FIRST: begin
               word_ff <= glyph;
               if (is_merge_mark(ch)) begin
                  idx_ff   <= idx_ff + IDX_W'(2);
                  state_ff <= R_SECOND;
               end else begin
                  idx_ff   <= idx_ff + IDX_W'(1);
                  state_ff <= R_EMIT;
               end
            end
            R_SECOND: begin
               word_ff  <= word_ff | glyph;
               state_ff <= R_EMIT;
            end
            R_EMIT: begin
               if (rsp.ready) begin
                  if (k_ff == LAST_K) begin
                     state_ff <= R_IDLE;
                  end else begin
                     k_ff     <= k_ff + K_W'(1);
                     state_ff <= R_FETCH;
                  end
               end
            end
            default: begin
               state_ff <= R_IDLE;
            end
         endcase
      end
   end

   assign idle          = (state_ff == R_IDLE);
   assign rsp.valid     = (state_ff == R_EMIT);
   assign rsp.position  = k_ff[POS_W-1:0];
   assign rsp.segments  = word_ff;
   assign rsp.last_word = (k_ff == LAST_K);

endmodule

### rtl/sstd_checker.sv
// Port-level checks of the scrolling segment text display, bound to the top level.
// Depends on sstd_pkg and scrolling_segment_text_display.
`timescale 1ns / 1ps

module sstd_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic                       req_op,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [sstd_pkg::POS_W-1:0] rsp_position,
   input logic                       rsp_last_word
);
   import sstd_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp valid dropped before transfer");

   a_busy_while_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request taken while a word is pending");

   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_op == OP_LOAD) |=> !rsp_valid)
      else $error("load produced a word");

   a_last_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_word |-> rsp_position == POS_W'(DISPLAY_CHARS - 1))
      else $error("last word at wrong position");

   a_refresh_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_word |=> !req_ready)
      else $error("request taken in the middle of a refresh");

endmodule

bind scrolling_segment_text_display sstd_checker u_sstd_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_chan.valid),
   .req_ready     (req_chan.ready),
   .req_op        (req_chan.op),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_position  (rsp_chan.position),
   .rsp_last_word (rsp_chan.last_word)
);

### tb/sv/tb_scrolling_segment_text_display.sv
// Self-checking bench for the scrolling segment text display: loads texts, sends refresh ticks
// and checks every display word against an in-bench text and scroll predictor.
// Depends on sstd_pkg, the sstd_req_if/sstd_rsp_if channels and the display RTL.
`timescale 1ns / 1ps

module tb_scrolling_segment_text_display;
   import sstd_pkg::*;

   localparam int LIMIT        = 400000;
   localparam int SCRIPT_LEN   = 25;
   localparam int RANDOM_ITEMS = 135;
   localparam int CALM_ITEMS   = 30;
   localparam int LONG_START   = 40;
   localparam int LONG_TEXT    = 64;
   localparam int DRAIN_CYCLES = 48;
   localparam int PAUSE_TICKS  = 4;
   localparam int STEP_TICKS   = 2;

   localparam logic [6:0] CH_SPACE = 7'h20;
   localparam logic [6:0] CH_DOT   = 7'h2E;
   localparam logic [6:0] CH_COLON = 7'h3A;
   localparam logic [6:0] CH_SEMI  = 7'h3B;

   localparam logic [15:0] SEG_A = 16'h0080, SEG_B = 16'h0040, SEG_C = 16'h0020;
   localparam logic [15:0] SEG_D = 16'h0010, SEG_E = 16'h2000, SEG_F = 16'h4000;
   localparam logic [15:0] SEG_G = 16'h0400, SEG_H = 16'h0800, SEG_J = 16'h0008;
   localparam logic [15:0] SEG_K = 16'h0004, SEG_M = 16'h0002, SEG_N = 16'h0001;
   localparam logic [15:0] SEG_P = 16'h0100, SEG_Q = 16'h0200;
   localparam logic [15:0] SEG_DOT = 16'h1000, SEG_COL = 16'h8000, SEG_NONE = 16'h0000;

   localparam logic [15:0] GLYPH [128] = '{
      SEG_NONE, SEG_NONE, SEG_NONE, SEG_NONE, SEG_NONE, SEG_NONE, SEG_NONE, SEG_NONE,
      SEG_NONE, SEG_NONE, SEG_NONE, SEG_NONE, SEG_NONE, SEG_NONE, SEG_NONE, SEG_NONE,
      SEG_NONE, SEG_NONE, SEG_NONE, SEG_NONE, SEG_NONE, SEG_NONE, SEG_NONE, SEG_NONE,
      SEG_NONE, SEG_NONE, SEG_NONE, SEG_NONE, SEG_NONE, SEG_NONE, SEG_NONE, SEG_NONE,
      SEG_NONE, SEG_NONE, SEG_F|SEG_J, SEG_NONE, SEG_NONE,
      SEG_F|SEG_G|SEG_H|SEG_K|SEG_Q|SEG_M|SEG_N|SEG_C, SEG_NONE, SEG_J,
      SEG_NONE, SEG_NONE, SEG_G|SEG_H|SEG_J|SEG_K|SEG_M|SEG_N|SEG_P|SEG_Q,
      SEG_G|SEG_J|SEG_M|SEG_P, SEG_DOT, SEG_G|SEG_M, SEG_DOT, SEG_K|SEG_Q,
      SEG_A|SEG_B|SEG_C|SEG_D|SEG_E|SEG_F, SEG_B|SEG_C,
      SEG_A|SEG_B|SEG_G|SEG_M|SEG_D|SEG_E, SEG_A|SEG_B|SEG_G|SEG_M|SEG_C|SEG_D,
      SEG_B|SEG_C|SEG_G|SEG_M|SEG_F, SEG_A|SEG_C|SEG_G|SEG_M|SEG_D|SEG_F,
      SEG_A|SEG_C|SEG_G|SEG_M|SEG_D|SEG_E|SEG_F, SEG_A|SEG_B|SEG_C,
      SEG_A|SEG_B|SEG_C|SEG_G|SEG_M|SEG_D|SEG_E|SEG_F,
      SEG_A|SEG_B|SEG_C|SEG_G|SEG_M|SEG_D|SEG_F,
      SEG_COL, SEG_COL, SEG_K|SEG_N, SEG_D|SEG_G|SEG_M, SEG_H|SEG_Q,
      SEG_A|SEG_B|SEG_M|SEG_P, SEG_A|SEG_B|SEG_E|SEG_F|SEG_K|SEG_M,
      SEG_A|SEG_B|SEG_C|SEG_G|SEG_M|SEG_E|SEG_F, SEG_A|SEG_B|SEG_C|SEG_D|SEG_J|SEG_M|SEG_P,
      SEG_A|SEG_D|SEG_E|SEG_F, SEG_A|SEG_B|SEG_C|SEG_D|SEG_J|SEG_P,
      SEG_A|SEG_D|SEG_E|SEG_F|SEG_G, SEG_A|SEG_E|SEG_F|SEG_G,
      SEG_A|SEG_C|SEG_D|SEG_E|SEG_F|SEG_M, SEG_B|SEG_C|SEG_E|SEG_F|SEG_G|SEG_M,
      SEG_A|SEG_D|SEG_J|SEG_P, SEG_B|SEG_C|SEG_D|SEG_E,
      SEG_E|SEG_F|SEG_G|SEG_K|SEG_N, SEG_D|SEG_E|SEG_F,
      SEG_B|SEG_C|SEG_E|SEG_F|SEG_H|SEG_K, SEG_B|SEG_C|SEG_E|SEG_F|SEG_H|SEG_N,
      SEG_A|SEG_B|SEG_C|SEG_D|SEG_E|SEG_F, SEG_A|SEG_B|SEG_E|SEG_F|SEG_G|SEG_M,
      SEG_A|SEG_B|SEG_C|SEG_D|SEG_E|SEG_F|SEG_N, SEG_A|SEG_B|SEG_E|SEG_F|SEG_G|SEG_M|SEG_N,
      SEG_A|SEG_C|SEG_D|SEG_F|SEG_G|SEG_M, SEG_A|SEG_J|SEG_P,
      SEG_B|SEG_C|SEG_D|SEG_E|SEG_F, SEG_E|SEG_F|SEG_K|SEG_Q,
      SEG_B|SEG_C|SEG_E|SEG_F|SEG_N|SEG_Q, SEG_H|SEG_K|SEG_N|SEG_Q,
      SEG_H|SEG_K|SEG_P, SEG_A|SEG_D|SEG_K|SEG_Q,
      SEG_A|SEG_D|SEG_J|SEG_P, SEG_H|SEG_N, SEG_A|SEG_D|SEG_J|SEG_P, SEG_Q|SEG_N,
      SEG_D, SEG_Q,
      SEG_D|SEG_E|SEG_G|SEG_N, SEG_C|SEG_D|SEG_E|SEG_F|SEG_G|SEG_M,
      SEG_D|SEG_E|SEG_G|SEG_M, SEG_B|SEG_C|SEG_D|SEG_E|SEG_G|SEG_M,
      SEG_D|SEG_E|SEG_G|SEG_Q, SEG_A|SEG_J|SEG_M|SEG_P,
      SEG_C|SEG_D|SEG_M|SEG_N, SEG_C|SEG_E|SEG_F|SEG_G|SEG_M,
      SEG_P, SEG_P|SEG_D, SEG_J|SEG_P|SEG_N|SEG_M, SEG_D|SEG_J|SEG_P,
      SEG_C|SEG_E|SEG_G|SEG_M|SEG_P, SEG_C|SEG_G|SEG_M|SEG_P,
      SEG_C|SEG_D|SEG_E|SEG_G|SEG_M, SEG_E|SEG_F|SEG_G|SEG_H,
      SEG_B|SEG_C|SEG_K|SEG_M, SEG_M|SEG_P, SEG_D|SEG_M|SEG_N, SEG_G|SEG_J|SEG_M|SEG_P,
      SEG_C|SEG_D|SEG_E, SEG_E|SEG_Q, SEG_C|SEG_E|SEG_N|SEG_Q, SEG_G|SEG_M|SEG_N|SEG_Q,
      SEG_C|SEG_D|SEG_N, SEG_D|SEG_G|SEG_Q,
      SEG_G|SEG_J|SEG_P, SEG_J|SEG_P, SEG_J|SEG_M|SEG_P, SEG_G|SEG_M, SEG_A|SEG_B|SEG_M|SEG_P
   };

   typedef struct packed {
      logic [POS_W-1:0] position;
      logic [SEG_W-1:0] segments;
      logic             last_word;
   } disp_word_type;

   typedef struct packed {
      op_type      op;
      logic [6:0]  ch;
      logic        fin;
      logic        pinned;
      logic [15:0] pin_word;
   } script_row_type;

   logic clock;
   logic reset;
   int   cycles;
   int   errors;
   bit   calm;

   sstd_req_if req_chan ();
   sstd_rsp_if rsp_chan ();

   scrolling_segment_text_display uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   logic [6:0]        text_mem [STORE_DEPTH];
   logic [7:0]        char_cnt     = '0;
   logic [7:0]        vis_len      = '0;
   logic [1:0]        pad_cnt      = '0;
   logic signed [8:0] scroll_pos   = '0;
   logic [2:0]        scroll_delay = '0;
   logic              text_done    = 1'b0;

   disp_word_type  due_words [$];
   script_row_type script [SCRIPT_LEN];

   function automatic logic [6:0] cell_char(int idx);
      int j;
      if (idx < int'(pad_cnt)) return CH_SPACE;
      j = idx - int'(pad_cnt);
      if (j < int'(char_cnt) && j < STORE_DEPTH) return text_mem[j[ADDR_W-1:0]];
      return CH_SPACE;
   endfunction

   function automatic void store_char(logic [6:0] ch, logic fin);
      int extra;
      int grown;
      if (text_done) begin
         char_cnt  = '0;
         vis_len   = '0;
         pad_cnt   = '0;
         text_done = 1'b0;
      end
      if (int'(char_cnt) < STORE_DEPTH) text_mem[char_cnt[ADDR_W-1:0]] = ch;
      if (char_cnt != 8'hFF) char_cnt = char_cnt + 1'b1;
      if (ch != CH_DOT && ch != CH_COLON && vis_len != 8'hFF) vis_len = vis_len + 1'b1;
      scroll_pos = '0;
      if (fin) begin
         if (int'(vis_len) > DISPLAY_CHARS) begin
            extra   = int'(vis_len) - DISPLAY_CHARS;
            extra   = (extra > 2) ? 2 : extra;
            pad_cnt = extra[1:0];
            grown   = int'(vis_len) + 2 * extra;
            vis_len = (grown > 255) ? 8'hFF : grown[7:0];
         end
         text_done = 1'b1;
      end
   endfunction

   function automatic void advance_scroll();
      if (int'(vis_len) > DISPLAY_CHARS) begin
         if (scroll_delay == 0) begin
            scroll_pos   = scroll_pos + 9'sd1;
            scroll_delay = (scroll_pos == 0) ? 3'(PAUSE_TICKS) : 3'(STEP_TICKS);
         end
         scroll_delay = scroll_delay - 1'b1;
      end
      if (int'(scroll_pos) + DISPLAY_CHARS + 1 > int'(vis_len)) begin
         scroll_delay = 3'(PAUSE_TICKS);
         scroll_pos   = -scroll_pos;
      end
   endfunction

   function automatic void predict_refresh(logic pinned, logic [15:0] pin_word);
      int            idx;
      logic [6:0]    ch;
      logic [15:0]   word;
      disp_word_type w;
      advance_scroll();
      idx = (scroll_pos < 0) ? -int'(scroll_pos) : int'(scroll_pos);
      for (int k = 0; k < DISPLAY_CHARS; k++) begin
         ch   = cell_char(idx);
         word = GLYPH[ch];
         if (ch == CH_DOT || ch == CH_COLON || ch == CH_SEMI) begin
            idx++;
            word = word | GLYPH[cell_char(idx)];
         end
         idx++;
         w.position  = k[POS_W-1:0];
         w.segments  = (pinned && k == 0) ? pin_word : word;
         w.last_word = (k == DISPLAY_CHARS - 1);
         due_words.push_back(w);
      end
   endfunction

   task automatic send_item(op_type op, logic [6:0] ch, logic fin, logic pinned,
                            logic [15:0] pin_word);
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.op        <= op;
      req_chan.char_code <= ch;
      req_chan.last      <= fin;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      if (op == OP_TICK) predict_refresh(pinned, pin_word);
      else store_char(ch, fin);
   endtask

   function automatic logic [6:0] pick_char();
      unique case ($urandom_range(0, 7))
         0: return CH_DOT;
         1: return CH_COLON;
         2: return CH_SEMI;
         default: return 7'($urandom_range(0, 127));
      endcase
   endfunction

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("scrolling_segment_text_display: mismatch");
         $finish;
      end
   end

   initial begin
      rsp_chan.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (!calm && $urandom_range(0, 2) == 0) begin
            rsp_chan.ready <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         repeat ($urandom_range(1, 24)) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      disp_word_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (due_words.size() == 0) begin
            errors++;
            $display("%0t: unexpected word pos %0d seg %h last %0b", $time,
                     rsp_chan.position, rsp_chan.segments, rsp_chan.last_word);
         end else begin
            want = due_words.pop_front();
            if (rsp_chan.position !== want.position || rsp_chan.segments !== want.segments ||
                rsp_chan.last_word !== want.last_word) begin
               errors++;
               $display("%0t: expected pos %0d seg %h last %0b, got pos %0d seg %h last %0b",
                        $time, want.position, want.segments, want.last_word,
                        rsp_chan.position, rsp_chan.segments, rsp_chan.last_word);
            end
         end
      end
   end

   initial begin
      int         n_rand;
      int         len;
      int         ticks;
      bit         long_done;
      logic [6:0] ch;

      calm               = 1'b0;
      long_done          = 1'b0;
      n_rand             = 0;
      reset              <= 1'b1;
      req_chan.valid     <= 1'b0;
      req_chan.op        <= OP_LOAD;
      req_chan.char_code <= '0;
      req_chan.last      <= 1'b0;

      // blank display after reset, single glyph, then marks and code extremes
      script[0]  = '{OP_TICK, 7'h00, 1'b0, 1'b1, 16'h0000};
      script[1]  = '{OP_LOAD, 7'h41, 1'b1, 1'b0, 16'h0000};
      script[2]  = '{OP_TICK, 7'h00, 1'b0, 1'b1, 16'h64E2};
      script[3]  = '{OP_LOAD, 7'h38, 1'b0, 1'b0, 16'h0000};
      script[4]  = '{OP_LOAD, CH_DOT, 1'b0, 1'b0, 16'h0000};
      script[5]  = '{OP_LOAD, CH_COLON, 1'b0, 1'b0, 16'h0000};
      script[6]  = '{OP_LOAD, CH_SEMI, 1'b0, 1'b0, 16'h0000};
      script[7]  = '{OP_LOAD, 7'h7F, 1'b0, 1'b0, 16'h0000};
      script[8]  = '{OP_LOAD, 7'h00, 1'b1, 1'b0, 16'h0000};
      script[9]  = '{OP_TICK, 7'h7F, 1'b1, 1'b0, 16'h0000};
      // padded text with a refresh mid-load and a trailing colon
      script[10] = '{OP_LOAD, 7'h57, 1'b0, 1'b0, 16'h0000};
      script[11] = '{OP_LOAD, 7'h49, 1'b0, 1'b0, 16'h0000};
      script[12] = '{OP_LOAD, 7'h44, 1'b0, 1'b0, 16'h0000};
      script[13] = '{OP_LOAD, 7'h45, 1'b0, 1'b0, 16'h0000};
      script[14] = '{OP_TICK, 7'h00, 1'b0, 1'b0, 16'h0000};
      script[15] = '{OP_LOAD, CH_SPACE, 1'b0, 1'b0, 16'h0000};
      script[16] = '{OP_LOAD, 7'h54, 1'b0, 1'b0, 16'h0000};
      script[17] = '{OP_LOAD, 7'h45, 1'b0, 1'b0, 16'h0000};
      script[18] = '{OP_LOAD, 7'h58, 1'b0, 1'b0, 16'h0000};
      script[19] = '{OP_LOAD, CH_COLON, 1'b1, 1'b0, 16'h0000};
      for (int i = 20; i < SCRIPT_LEN; i++) script[i] = '{OP_TICK, 7'h00, 1'b0, 1'b0, 16'h0000};

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < SCRIPT_LEN; i++)
         send_item(script[i].op, script[i].ch, script[i].fin, script[i].pinned,
                   script[i].pin_word);

      while (n_rand < RANDOM_ITEMS) begin
         calm = (n_rand >= RANDOM_ITEMS - CALM_ITEMS);
         if (!long_done && n_rand >= LONG_START) begin
            // load one long text and scroll it
            for (int i = 0; i < LONG_TEXT; i++)
               send_item(OP_LOAD, 7'($urandom_range(0, 127)), i == LONG_TEXT - 1, 1'b0, '0);
            for (int i = 0; i < 8; i++) send_item(OP_TICK, pick_char(), 1'b0, 1'b0, '0);
            long_done = 1'b1;
            n_rand += LONG_TEXT + 8;
         end else if ($urandom_range(0, 4) == 0) begin
            len = $urandom_range(1, 6);
            for (int i = 0; i < len; i++)
               send_item(op_type'($urandom_range(0, 1)), 7'($urandom_range(0, 127)),
                         1'($urandom_range(0, 1)), 1'b0, '0);
            n_rand += len;
         end else begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 12);
            for (int i = 0; i < len; i++) begin
               if ($urandom_range(0, 11) == 0) begin
                  send_item(OP_TICK, '0, 1'b0, 1'b0, '0);
                  n_rand++;
               end
               ch = pick_char();
               send_item(OP_LOAD, ch, i == len - 1, 1'b0, '0);
            end
            ticks = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 45) : $urandom_range(1, 12);
            for (int i = 0; i < ticks; i++)
               send_item(OP_TICK, pick_char(), 1'($urandom_range(0, 1)), 1'b0, '0);
            n_rand += len + ticks;
         end
      end

      req_chan.valid <= 1'b0;
      while (due_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("scrolling_segment_text_display: match");
      end else begin
         $display("scrolling_segment_text_display: mismatch");
      end
      $finish;
   end

endmodule

### filelist.f
rtl/sstd_pkg.sv
rtl/sstd_if.sv
rtl/sstd_ram.sv
rtl/sstd_text_ctl.sv
rtl/sstd_render.sv
rtl/scrolling_segment_text_display.sv
rtl/sstd_checker.sv
tb/sv/tb_scrolling_segment_text_display.sv
